/* hw/rtl/tdpb_pkg.sv */
// tail-drop packet buffer: shared widths, reset values and control structs
// no dependencies; used by the interfaces and by every module of the block but tdpb_ram
package tdpb_pkg;

   localparam int TIME_W               = 32;
   localparam int DUR_W                = 16;
   localparam int SIZE_W               = 7;
   localparam int DEFAULT_BUFFER_DEPTH = 64;

   localparam logic [SIZE_W-1:0] BUFFER_SIZE_RESET = 7'd64;

   typedef struct packed {
      logic latch_input;
      logic read_head;
      logic pop_head;
      logic push_entry;
      logic load_result;
   } ctrl_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic head_done;
      logic full;
   } ctrl_status_type;

endpackage

/* hw/rtl/tdpb_if.sv */
// valid/ready channel interfaces for packets, results and the size register
// depends on tdpb_pkg
interface tdpb_req_if;
   import tdpb_pkg::*;
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] arrival_time;
   logic [DUR_W-1:0]  process_time;
   modport source (output valid, output arrival_time, output process_time, input ready);
   modport sink   (input valid, input arrival_time, input process_time, output ready);
endinterface

interface tdpb_rsp_if;
   import tdpb_pkg::*;
   logic              valid;
   logic              ready;
   logic              dropped;
   logic [TIME_W-1:0] start_time;
   modport source (output valid, output dropped, output start_time, input ready);
   modport sink   (input valid, input dropped, input start_time, output ready);
endinterface

interface tdpb_csr_if;
   import tdpb_pkg::*;
   logic              valid;
   logic              ready;
   logic [SIZE_W-1:0] buffer_size;
   modport source (output valid, output buffer_size, input ready);
   modport sink   (input valid, input buffer_size, output ready);
endinterface

/* hw/rtl/tdpb_ram.sv */
// generic single write port ram with registered read
// no dependencies
module tdpb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/tdpb_ctrl.sv */
// controller: sequences head pops, the drop decision and the result register
// depends on tdpb_pkg
module tdpb_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  tdpb_pkg::ctrl_status_type status,
   output tdpb_pkg::ctrl_cmd_type    cmd
);
   import tdpb_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_CMP,
      ST_DECIDE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_input = 1'b1;
               state_in        = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (status.count_zero) begin
               state_in = ST_DECIDE;
            end else begin
               cmd.read_head = 1'b1;
               state_in      = ST_CMP;
            end
         end
         ST_CMP: begin
            if (status.head_done) begin
               cmd.pop_head = 1'b1;
               state_in     = ST_FETCH;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               cmd.load_result = 1'b1;
               cmd.push_entry  = !status.full;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* hw/rtl/tdpb_datapath.sv */
// datapath: finish time fifo, occupancy, start/finish arithmetic, result register
// depends on tdpb_pkg and tdpb_ram
module tdpb_datapath #(
   parameter int BUFFER_DEPTH = tdpb_pkg::DEFAULT_BUFFER_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [tdpb_pkg::TIME_W-1:0] req_arrival_time,
   input  logic [tdpb_pkg::DUR_W-1:0]  req_process_time,
   input  logic                        csr_write,
   input  logic [tdpb_pkg::SIZE_W-1:0] csr_buffer_size,
   input  tdpb_pkg::ctrl_cmd_type      cmd,
   output tdpb_pkg::ctrl_status_type   status,
   output logic                        rsp_dropped,
   output logic [tdpb_pkg::TIME_W-1:0] rsp_start_time
);
   import tdpb_pkg::*;

   localparam int PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
   localparam int CMP_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
   localparam int SUM_W = PTR_W + 2;

   logic [TIME_W-1:0] arrival_ff;
   logic [DUR_W-1:0]  duration_ff;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TIME_W-1:0] last_finish_ff, last_finish_in;
   logic [SIZE_W-1:0] buffer_size_ff;
   logic              dropped_ff;
   logic [TIME_W-1:0] start_ff;

   logic [TIME_W-1:0] head_finish;
   logic [CMP_W-1:0]  capacity;
   logic [SUM_W-1:0]  tail_sum;
   logic [PTR_W-1:0]  tail;
   logic [TIME_W-1:0] start;
   logic [TIME_W:0]   finish_sum;
   logic [TIME_W-1:0] finish;

   tdpb_ram #(
      .WIDTH (TIME_W),
      .DEPTH (BUFFER_DEPTH),
      .ADDR_W(PTR_W)
   ) u_finish_ram (
      .clock  (clock),
      .wr_en  (cmd.push_entry),
      .wr_addr(tail),
      .wr_data(finish),
      .rd_en  (cmd.read_head),
      .rd_addr(head_ff),
      .rd_data(head_finish)
   );

   assign capacity = (CMP_W'(buffer_size_ff) > CMP_W'(BUFFER_DEPTH)) ?
                     CMP_W'(BUFFER_DEPTH) : CMP_W'(buffer_size_ff);

   assign status.count_zero = (count_ff == '0);
   assign status.head_done  = (head_finish <= arrival_ff);
   assign status.full       = (CMP_W'(count_ff) >= capacity);

   always_comb begin
      tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
      if (tail_sum >= SUM_W'(BUFFER_DEPTH)) begin
         tail_sum = tail_sum - SUM_W'(BUFFER_DEPTH);
      end
      tail = tail_sum[PTR_W-1:0];
   end

   assign start      = (arrival_ff > last_finish_ff) ? arrival_ff : last_finish_ff;
   assign finish_sum = {1'b0, start} + (TIME_W + 1)'(duration_ff);
   assign finish     = finish_sum[TIME_W] ? {TIME_W{1'b1}} : finish_sum[TIME_W-1:0];

   always_comb begin
      head_in        = head_ff;
      count_in       = count_ff;
      last_finish_in = last_finish_ff;
      if (cmd.pop_head) begin
         head_in  = (head_ff == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
      if (cmd.push_entry) begin
         count_in       = count_ff + 1'b1;
         last_finish_in = finish;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff        <= '0;
         count_ff       <= '0;
         last_finish_ff <= '0;
         buffer_size_ff <= BUFFER_SIZE_RESET;
      end else begin
         head_ff        <= head_in;
         count_ff       <= count_in;
         last_finish_ff <= last_finish_in;
         if (csr_write) begin
            buffer_size_ff <= csr_buffer_size;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_input) begin
         arrival_ff  <= req_arrival_time;
         duration_ff <= req_process_time;
      end
      if (cmd.load_result) begin
         dropped_ff <= status.full;
         start_ff   <= status.full ? '0 : start;
      end
   end

   assign rsp_dropped    = dropped_ff;
   assign rsp_start_time = start_ff;

endmodule

/* hw/rtl/tail_drop_packet_buffer_top.sv */
// channel   | dir | payload                      | transaction when
// req_chan  | in  | arrival_time, process_time   | valid && ready
// rsp_chan  | out | dropped, start_time          | valid && ready
// csr_chan  | in  | buffer_size                  | valid && ready (ready held high)
//
// one packet in flight: the controller latches it, then for each head entry reads its
// finish time and pops it if finished, going straight to the decision when the fifo is
// empty; each pop is a registered read of the finish time ram
// synchronous active-high reset empties the fifo and sets buffer_size to 64
// a result waits in the output register while the next packet is taken;
// a packet that reaches its decision with that register still full waits there
// depends on tdpb_pkg, tdpb_if, tdpb_ram, tdpb_ctrl, tdpb_datapath
module tail_drop_packet_buffer_top #(
   parameter int BUFFER_DEPTH = tdpb_pkg::DEFAULT_BUFFER_DEPTH
) (
   input logic       clock,
   input logic       reset,
   tdpb_req_if.sink  req_chan,
   tdpb_rsp_if.source rsp_chan,
   tdpb_csr_if.sink  csr_chan
);
   import tdpb_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   assign csr_chan.ready = 1'b1;

   tdpb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_chan.valid),
      .req_ready(req_chan.ready),
      .rsp_valid(rsp_chan.valid),
      .rsp_ready(rsp_chan.ready),
      .status   (status),
      .cmd      (cmd)
   );

   tdpb_datapath #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_arrival_time(req_chan.arrival_time),
      .req_process_time(req_chan.process_time),
      .csr_write       (csr_chan.valid && csr_chan.ready),
      .csr_buffer_size (csr_chan.buffer_size),
      .cmd             (cmd),
      .status          (status),
      .rsp_dropped     (rsp_chan.dropped),
      .rsp_start_time  (rsp_chan.start_time)
   );

endmodule

/* hw/rtl/tdpb_checker.sv */
// port-level checks on the packet buffer top, attached by bind
// depends on tdpb_pkg and tail_drop_packet_buffer_top
module tdpb_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_dropped,
   input logic [tdpb_pkg::TIME_W-1:0] rsp_start_time
);
   import tdpb_pkg::*;

   a_reset_clears_rsp : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_drop_zero_start : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_dropped) |-> (rsp_start_time == '0))
      else $error("dropped packet with nonzero start time");

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("new packet taken in the cycle after a transaction");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_dropped) && $stable(rsp_start_time)))
      else $error("stalled result changed or vanished");

endmodule

bind tail_drop_packet_buffer_top tdpb_checker u_tdpb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_dropped   (rsp_chan.dropped),
   .rsp_start_time(rsp_chan.start_time)
);

/* test/tail_drop_packet_buffer_top_test.sv */
`timescale 1ns / 100ps
// testbench for tail_drop_packet_buffer_top: directed and random packet streams with
// randomized stalls, every result compared against a behavioral tail-drop fifo model
// depends on tdpb_pkg, tdpb_if and the rtl of the block
module tail_drop_packet_buffer_top_test;
   import tdpb_pkg::*;

   localparam int DEPTH = DEFAULT_BUFFER_DEPTH;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;
   localparam int CLK_PERIOD = 20;
   localparam int SETTLE_CYCLES = 40;
   localparam int BURST_MAX = 13;
   localparam int HOLD_CYCLES = 400;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_PACKETS = 110;

   typedef struct packed {
      logic              dropped;
      logic [TIME_W-1:0] start_time;
   } outcome_type;

   logic clock;
   logic reset;

   tdpb_req_if req_chan ();
   tdpb_rsp_if rsp_chan ();
   tdpb_csr_if csr_chan ();

   tail_drop_packet_buffer_top #(.BUFFER_DEPTH(DEPTH)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   logic [TIME_W-1:0] queued_finish[$];
   logic [TIME_W-1:0] model_last_finish;
   logic [SIZE_W-1:0] model_size;
   outcome_type       expected_outcomes[$];
   logic [TIME_W-1:0] now_arrival;
   int                error_count;
   int                req_idle_pct;
   int                rsp_idle_pct;
   int                rsp_hold_cycles;

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(5_000_000);
      $display("tail_drop_packet_buffer_top verification failed");
      $finish;
   end

   function automatic outcome_type tail_drop_decide(input logic [TIME_W-1:0] arrival,
                                                    input logic [DUR_W-1:0]  duration);
      outcome_type     result;
      logic [TIME_W:0] sum;
      int              capacity;
      while (queued_finish.size() > 0 && queued_finish[0] <= arrival)
         void'(queued_finish.pop_front());
      capacity = (model_size > DEPTH) ? DEPTH : model_size;
      result.dropped = 1'b0;
      result.start_time = '0;
      if (queued_finish.size() >= capacity) begin
         result.dropped = 1'b1;
         return result;
      end
      result.start_time = (arrival > model_last_finish) ? arrival : model_last_finish;
      sum = {1'b0, result.start_time} + (TIME_W + 1)'(duration);
      model_last_finish = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
      queued_finish.push_back(model_last_finish);
      return result;
   endfunction

   task automatic send_packet(input logic [TIME_W-1:0] arrival,
                              input logic [DUR_W-1:0]  duration);
      @(negedge clock);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, BURST_MAX)) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.arrival_time <= arrival;
      req_chan.process_time <= duration;
      do @(posedge clock); while (!req_chan.ready);
      expected_outcomes.push_back(tail_drop_decide(arrival, duration));
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_buffer_size(input logic [SIZE_W-1:0] size);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.buffer_size <= size;
      do @(posedge clock); while (!csr_chan.ready);
      model_size = size;
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // result side: long hold, random stall bursts or ready
   initial begin : result_receiver
      int gap_left;
      gap_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_chan.ready <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_chan.ready <= 1'b0;
         end else if ($urandom_range(0, 99) < rsp_idle_pct) begin
            gap_left = $urandom_range(1, BURST_MAX) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_outcomes.size() == 0) begin
            error_count++;
            $display("%0t: result with no packet pending: expected none, %s%0b %s%0h",
                     $time, "actual dropped=", rsp_chan.dropped,
                     "start_time=", rsp_chan.start_time);
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_chan.dropped !== want.dropped) begin
               error_count++;
               $display("%0t: dropped mismatch: expected %0b, actual %0b",
                        $time, want.dropped, rsp_chan.dropped);
            end
            if (rsp_chan.start_time !== want.start_time) begin
               error_count++;
               $display("%0t: start_time mismatch: expected %0h, actual %0h",
                        $time, want.start_time, rsp_chan.start_time);
            end
         end
      end
   end

   task automatic test_directed_basics();
      req_idle_pct = 20;
      rsp_idle_pct = 20;
      send_packet(32'd0, 16'd0);
      send_packet(32'd0, 16'd0);
      send_packet(32'd0, 16'hFFFF);
      send_packet(32'd1, 16'd100);
      send_packet(32'd2, 16'd0);
      // decreasing arrival
      send_packet(32'd1, 16'd7);
      send_packet(32'd65635, 16'd1);
      drain_results();
   endtask

   task automatic test_size_extremes();
      write_buffer_size(7'd0);
      now_arrival = model_last_finish + 32'd100000;
      repeat (3) send_packet(now_arrival, 16'($urandom_range(0, 65535)));
      drain_results();
      write_buffer_size(7'd1);
      now_arrival = now_arrival + 32'd100000;
      send_packet(now_arrival, 16'd50);
      send_packet(now_arrival + 32'd10, 16'd5);
      send_packet(now_arrival + 32'd50, 16'd0);
      send_packet(now_arrival + 32'd50, 16'd3);
      now_arrival = now_arrival + 32'd50;
      drain_results();
   endtask

   task automatic test_full_depth();
      write_buffer_size(7'd127);
      now_arrival = model_last_finish + 32'd1000;
      repeat (DEPTH + 6) send_packet(now_arrival, 16'($urandom_range(1, 65535)));
      drain_results();
      // capacity lowered below the current occupancy
      write_buffer_size(7'd3);
      repeat (12) begin
         now_arrival = now_arrival + $urandom_range(20000, 200000);
         send_packet(now_arrival, 16'($urandom_range(0, 65535)));
      end
      drain_results();
      write_buffer_size(7'd64);
      repeat (4) send_packet(now_arrival, 16'($urandom_range(0, 4095)));
      drain_results();
   endtask

   task automatic test_output_backpressure();
      write_buffer_size(7'd8);
      req_idle_pct = 0;
      rsp_idle_pct = 10;
      now_arrival = model_last_finish + 32'd10;
      rsp_hold_cycles = HOLD_CYCLES;
      repeat (40) begin
         now_arrival = now_arrival + $urandom_range(0, 300);
         send_packet(now_arrival, 16'($urandom_range(0, 1000)));
      end
      drain_results();
   endtask

   task automatic test_random_traffic();
      int dur_max;
      int spacing_max;
      int pick;
      logic [SIZE_W-1:0] size;
      logic [DUR_W-1:0] duration;
      logic [TIME_W-1:0] arrival;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 9))
            0: size = SIZE_W'($urandom_range(65, 127));
            1, 2: size = SIZE_W'($urandom_range(9, 64));
            default: size = SIZE_W'($urandom_range(1, 8));
         endcase
         write_buffer_size(size);
         case ($urandom_range(0, 3))
            0: dur_max = 15;
            1: dur_max = 255;
            2: dur_max = 4095;
            default: dur_max = 65535;
         endcase
         spacing_max = (dur_max * $urandom_range(1, 6)) / 4;
         if (phase == RANDOM_PHASES - 1) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 35);
            rsp_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 35);
         end
         now_arrival = now_arrival + $urandom_range(1 << 28, 1 << 29);
         for (int n = 0; n < PHASE_PACKETS; n++) begin
            pick = $urandom_range(0, 31);
            if (pick == 0)
               duration = 16'($urandom_range(0, 65535));
            else if (pick == 1)
               duration = '0;
            else
               duration = 16'($urandom_range(0, dur_max));
            if (pick == 2) begin
               arrival = now_arrival - $urandom_range(1, 1000);
            end else begin
               now_arrival = now_arrival + $urandom_range(0, spacing_max);
               arrival = now_arrival;
            end
            send_packet(arrival, duration);
         end
         drain_results();
      end
   endtask

   task automatic test_time_saturation();
      write_buffer_size(7'd2);
      send_packet(32'hFFFF_FFF0, 16'hFFFF);
      send_packet(32'hFFFF_FFF8, 16'd0);
      send_packet(32'hFFFF_FFF9, 16'd1);
      send_packet(32'd5, 16'd3);
      send_packet(TIME_MAX, 16'hFFFF);
      send_packet(32'd7, 16'd0);
      drain_results();
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.arrival_time = '0;
      req_chan.process_time = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.buffer_size = BUFFER_SIZE_RESET;
      error_count = 0;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      rsp_hold_cycles = 0;
      model_size = BUFFER_SIZE_RESET;
      model_last_finish = '0;
      now_arrival = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_basics();
      test_size_extremes();
      test_full_depth();
      test_output_backpressure();
      test_random_traffic();
      test_time_saturation();

      if (error_count == 0)
         $display("tail_drop_packet_buffer_top verification clean");
      else
         $display("tail_drop_packet_buffer_top verification failed");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/tdpb_pkg.sv
hw/rtl/tdpb_if.sv
hw/rtl/tdpb_ram.sv
hw/rtl/tdpb_ctrl.sv
hw/rtl/tdpb_datapath.sv
hw/rtl/tail_drop_packet_buffer_top.sv
hw/rtl/tdpb_checker.sv
test/tail_drop_packet_buffer_top_test.sv
